@@ hw/rtl/ppmat_pkg.sv @@
// ---------------------------------------------------------------------------
// ppmat_pkg
// Shared types and constants for the image-to-terminal-text converter.
// ---------------------------------------------------------------------------
package ppmat_pkg;

  localparam int unsigned QDEPTH = 4;

  typedef enum logic [1:0] {
    KIND_C0 = 2'd0,
    KIND_C1 = 2'd1,
    KIND_C2 = 2'd2
  } kind_t;

  // One pixel component, ready for printing.
  typedef struct packed {
    kind_t            kind;
    logic             eol;
    logic [1:0]       ndig;
    logic [3:0]       dig2;
    logic [3:0]       dig1;
    logic [3:0]       dig0;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic       ready;
  } hs_t;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] BLK_B0   = 8'hE2;
  localparam logic [7:0] BLK_B1   = 8'h96;
  localparam logic [7:0] BLK_B2   = 8'h88;

endpackage

@@ hw/rtl/ppmat_if.sv @@
// ---------------------------------------------------------------------------
// ppmat_if
// Valid/ready channel interfaces for the byte input and the text output.
// ---------------------------------------------------------------------------
interface ppmat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface ppmat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ hw/rtl/ppmat_front.sv @@
// ---------------------------------------------------------------------------
// ppmat_front
// Header parser and pixel classifier: turns each component byte into a job.
// ---------------------------------------------------------------------------
module ppmat_front #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  ppmat_in_if.sink          in_ch,
  output ppmat_pkg::job_t   push_job,
  output logic              push_valid,
  input  logic              push_ready
);

  typedef enum logic [6:0] {
    PH_SKIP0  = 7'b0000001,
    PH_SKIP1  = 7'b0000010,
    PH_SKIP2  = 7'b0000100,
    PH_WIDTH  = 7'b0001000,
    PH_HEIGHT = 7'b0010000,
    PH_MAXV   = 7'b0100000,
    PH_PIXEL  = 7'b1000000
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [DIM_BITS-1:0]   acc_r, acc_nxt;
  logic [DIM_BITS-1:0]   width_r, width_nxt;
  logic [DIM_BITS-1:0]   height_r, height_nxt;
  logic [DIM_BITS-1:0]   col_r, col_nxt;
  logic [DIM_BITS-1:0]   row_r, row_nxt;
  ppmat_pkg::kind_t      comp_r, comp_nxt;

  logic                  fire;
  logic                  term;
  logic [DIM_BITS-1:0]   col_inc;
  logic [DIM_BITS-1:0]   row_inc;
  logic [DIM_BITS-1:0]   acc_mac;
  ppmat_pkg::job_t       job;

  function automatic ppmat_pkg::job_t dec_split(logic [7:0] v);
    ppmat_pkg::job_t r;
    logic [1:0]      h;
    logic [7:0]      rem;
    logic [15:0]     prod;
    logic [3:0]      t;
    logic [7:0]      t10;
    begin
      r = '0;
      h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
      rem = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
      prod = {8'h00, rem} * 16'd205;
      t = 4'(prod >> 11);
      t10 = ({4'h0, t} << 3) + ({4'h0, t} << 1);
      r.dig2 = {2'b00, h};
      r.dig1 = t;
      r.dig0 = 4'(rem - t10);
      r.ndig = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
      dec_split = r;
    end
  endfunction

  assign fire         = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = push_ready;
  assign term         = (in_ch.in_byte == ppmat_pkg::CH_SPACE) ||
                        (in_ch.in_byte == ppmat_pkg::CH_NL);
  assign col_inc      = col_r + DIM_BITS'(1);
  assign row_inc      = row_r + DIM_BITS'(1);
  assign acc_mac      = (acc_r << 3) + (acc_r << 1) + DIM_BITS'(in_ch.in_byte)
                        - DIM_BITS'(48);

  always_comb begin
    job      = dec_split(in_ch.in_byte);
    job.kind = comp_r;
    job.eol  = (comp_r == ppmat_pkg::KIND_C2) && (col_inc == width_r);
  end

  assign push_job   = job;
  assign push_valid = fire && (phase_r == PH_PIXEL);

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    comp_nxt   = comp_r;
    if (fire) begin
      case (phase_r)
        PH_SKIP0: phase_nxt = PH_SKIP1;
        PH_SKIP1: phase_nxt = PH_SKIP2;
        PH_SKIP2: phase_nxt = PH_WIDTH;
        PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
          if (term) begin
            acc_nxt = '0;
            if (phase_r == PH_WIDTH) begin
              width_nxt = acc_r;
              phase_nxt = PH_HEIGHT;
            end else if (phase_r == PH_HEIGHT) begin
              height_nxt = acc_r;
              phase_nxt  = PH_MAXV;
            end else begin
              col_nxt  = '0;
              row_nxt  = '0;
              comp_nxt = ppmat_pkg::KIND_C0;
              if ((width_r == '0) || (height_r == '0)) begin
                phase_nxt = PH_SKIP0;
              end else begin
                phase_nxt = PH_PIXEL;
              end
            end
          end else begin
            acc_nxt = acc_mac;
          end
        end
        PH_PIXEL: begin
          case (comp_r)
            ppmat_pkg::KIND_C0: comp_nxt = ppmat_pkg::KIND_C1;
            ppmat_pkg::KIND_C1: comp_nxt = ppmat_pkg::KIND_C2;
            default: begin
              comp_nxt = ppmat_pkg::KIND_C0;
              if (job.eol) begin
                col_nxt = '0;
                if (row_inc == height_r) begin
                  row_nxt   = '0;
                  phase_nxt = PH_SKIP0;
                end else begin
                  row_nxt = row_inc;
                end
              end else begin
                col_nxt = col_inc;
              end
            end
          endcase
        end
        default: phase_nxt = PH_SKIP0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SKIP0;
      acc_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      comp_r   <= ppmat_pkg::KIND_C0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      comp_r   <= comp_nxt;
    end
  end

endmodule

@@ hw/rtl/ppmat_queue.sv @@
// ---------------------------------------------------------------------------
// ppmat_queue
// Short job queue between the parser and the text generator.
// ---------------------------------------------------------------------------
module ppmat_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  ppmat_pkg::job_t  push_job,
  input  logic             push_valid,
  output logic             push_ready,
  output ppmat_pkg::job_t  pop_job,
  output ppmat_pkg::hs_t   pop_hs_o,
  input  logic             pop_ready
);

  localparam int unsigned PW = $clog2(ppmat_pkg::QDEPTH);

  ppmat_pkg::job_t  mem_r [ppmat_pkg::QDEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready     = (cnt_r != (PW+1)'(ppmat_pkg::QDEPTH));
  assign pop_hs_o.valid = (cnt_r != '0);
  assign pop_hs_o.ready = pop_ready;
  assign pop_job        = mem_r[rd_r];
  assign do_push        = push_valid && push_ready;
  assign do_pop         = pop_hs_o.valid && pop_ready;

  always_comb begin
    wr_nxt  = do_push ? wr_r + PW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + PW'(1) : rd_r;
    cnt_nxt = cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/ppmat_back.sv @@
// ---------------------------------------------------------------------------
// ppmat_back
// Text generator: expands each job into its escape sequence, one byte a cycle unless stalled.
// ---------------------------------------------------------------------------
module ppmat_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ppmat_pkg::job_t  pop_job,
  input  ppmat_pkg::hs_t   pop_hs_i,
  output logic             pop_ready,
  ppmat_out_if.source      out_ch
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  ppmat_pkg::job_t  cur_r, cur_nxt;
  logic             cur_v_r, cur_v_nxt;
  logic [3:0]       step_r, step_nxt;
  logic             out_v_r, out_v_nxt;
  beat_t            out_r, out_nxt;
  beat_t            beat;
  logic             adv;
  logic             take;

  function automatic logic [7:0] prefix_at(logic [2:0] i);
    logic [7:0] c;
    begin
      case (i)
        3'd0:    c = ppmat_pkg::CH_ESC;
        3'd1:    c = ppmat_pkg::CH_LBR;
        3'd2:    c = ppmat_pkg::CH_THREE;
        3'd3:    c = ppmat_pkg::CH_EIGHT;
        3'd4:    c = ppmat_pkg::CH_SEMI;
        3'd5:    c = ppmat_pkg::CH_TWO;
        default: c = ppmat_pkg::CH_SEMI;
      endcase
      prefix_at = c;
    end
  endfunction

  function automatic logic [7:0] suffix_at(logic [3:0] i);
    logic [7:0] c;
    begin
      case (i)
        4'd0:    c = ppmat_pkg::CH_M;
        4'd1:    c = ppmat_pkg::BLK_B0;
        4'd2:    c = ppmat_pkg::BLK_B1;
        4'd3:    c = ppmat_pkg::BLK_B2;
        4'd4:    c = ppmat_pkg::CH_ESC;
        4'd5:    c = ppmat_pkg::CH_LBR;
        4'd6:    c = ppmat_pkg::CH_ZERO;
        4'd7:    c = ppmat_pkg::CH_M;
        default: c = ppmat_pkg::CH_NL;
      endcase
      suffix_at = c;
    end
  endfunction

  function automatic beat_t beat_at(ppmat_pkg::job_t j, logic [3:0] step);
    beat_t      r;
    logic [3:0] pre;
    logic [3:0] nd;
    logic [3:0] s1;
    logic [3:0] s2;
    logic [3:0] p;
    logic [3:0] d;
    begin
      r.data = ppmat_pkg::CH_SEMI;
      r.last = 1'b0;
      pre = (j.kind == ppmat_pkg::KIND_C0) ? 4'd7 : 4'd0;
      nd  = {2'b00, j.ndig};
      s1  = step - pre;
      s2  = s1 - nd;
      p   = nd - 4'd1 - s1;
      case (p)
        4'd2:    d = j.dig2;
        4'd1:    d = j.dig1;
        default: d = j.dig0;
      endcase
      if (step < pre) begin
        r.data = prefix_at(step[2:0]);
      end else if (s1 < nd) begin
        r.data = ppmat_pkg::CH_ZERO + {4'h0, d};
      end else if (j.kind != ppmat_pkg::KIND_C2) begin
        r.data = ppmat_pkg::CH_SEMI;
        r.last = 1'b1;
      end else begin
        r.data = suffix_at(s2);
        r.last = j.eol ? (s2 == 4'd8) : (s2 == 4'd7);
      end
      beat_at = r;
    end
  endfunction

  assign beat      = beat_at(cur_r, step_r);
  assign adv       = cur_v_r && (!out_v_r || out_ch.ready);
  assign pop_ready = !cur_v_r || (adv && beat.last);
  assign take      = pop_hs_i.valid && pop_hs_i.ready;

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_byte    = out_r.data;
  assign out_ch.last_of_run = out_r.last;

  always_comb begin
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    step_nxt  = step_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (adv) begin
      out_nxt   = beat;
      out_v_nxt = 1'b1;
      step_nxt  = step_r + 4'd1;
      if (beat.last) begin
        cur_v_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
    if (take) begin
      cur_nxt   = pop_job;
      cur_v_nxt = 1'b1;
      step_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      step_r  <= 4'd0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      step_r  <= step_nxt;
      out_v_r <= out_v_nxt;
    end
  end

endmodule

@@ hw/rtl/ppm_to_ansi_truecolor_text.sv @@
// ---------------------------------------------------------------------------
// ppm_to_ansi_truecolor_text
// Converts a binary RGB image byte stream into true-colour terminal text.
// ---------------------------------------------------------------------------
//  channel | dir | payload                       | handshake
//  in_ch   | in  | in_byte[7:0]                  | valid / ready
//  out_ch  | out | out_byte[7:0], last_of_run    | valid / ready
//
// Header bytes produce no output.
// A pixel component expands into 2 to 12 output bytes, sent one at a time
// through the single-byte output register; a four-entry job queue lets the
// parser run ahead of the text generator.
// Reset is synchronous and active low; afterwards the parser expects a header.
// A stalled output holds its byte; the input stalls only when the queue fills.
module ppm_to_ansi_truecolor_text #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  ppmat_in_if.sink     in_ch,
  ppmat_out_if.source  out_ch
);

  ppmat_pkg::job_t  push_job;
  logic             push_valid;
  logic             push_ready;
  ppmat_pkg::job_t  pop_job;
  ppmat_pkg::hs_t   pop_hs;
  logic             pop_ready;

  ppmat_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  ppmat_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_hs_o   (pop_hs),
    .pop_ready  (pop_ready)
  );

  ppmat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_job   (pop_job),
    .pop_hs_i  (pop_hs),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

@@ hw/rtl/ppmat_checker.sv @@
// ---------------------------------------------------------------------------
// ppmat_checker
// Port-level checks on the converter's text output.
// ---------------------------------------------------------------------------
module ppmat_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("Stalled output item changed.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte == ppmat_pkg::CH_ESC) |-> !out_last)
    else $error("Escape byte ended a run.");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_byte == ppmat_pkg::CH_SEMI) ||
      (out_byte == ppmat_pkg::CH_M) || (out_byte == ppmat_pkg::CH_NL))
    else $error("Run ended on an unexpected byte.");

  a_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte == ppmat_pkg::CH_NL) |-> out_last)
    else $error("Newline not at the end of a run.");

endmodule

bind ppm_to_ansi_truecolor_text ppmat_checker u_ppmat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last_of_run)
);

@@ tb/sv/ppm_text_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppm_text_checker
// Watches both channels of the image-to-terminal-text converter. It renders
// every accepted input byte into the text that it should produce, then
// compares each accepted output byte and its end-of-run flag against the
// oldest outstanding character.
// ---------------------------------------------------------------------------
module ppm_text_checker #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  ppmat_in_if  in_ch,
  ppmat_out_if out_ch,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [6:0] {
    STEP_MAGIC0 = 7'b0000001,
    STEP_MAGIC1 = 7'b0000010,
    STEP_MAGIC2 = 7'b0000100,
    STEP_WIDTH  = 7'b0001000,
    STEP_HEIGHT = 7'b0010000,
    STEP_MAXVAL = 7'b0100000,
    STEP_PIXELS = 7'b1000000
  } parse_step_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       ends_run;
  } text_char_t;

  parse_step_t         step;
  logic [DIM_BITS-1:0] number_acc;
  logic [DIM_BITS-1:0] img_w;
  logic [DIM_BITS-1:0] img_h;
  logic [DIM_BITS-1:0] col;
  logic [DIM_BITS-1:0] row;
  ppmat_pkg::kind_t    comp;
  logic [7:0]          run_chars[$];
  text_char_t          text_expected[$];
  text_char_t          want;

  function automatic void add_decimal(input logic [7:0] v);
    if (v >= 8'd100) begin
      run_chars.push_back(ppmat_pkg::CH_ZERO + v / 8'd100);
      run_chars.push_back(ppmat_pkg::CH_ZERO + (v / 8'd10) % 8'd10);
      run_chars.push_back(ppmat_pkg::CH_ZERO + v % 8'd10);
    end else if (v >= 8'd10) begin
      run_chars.push_back(ppmat_pkg::CH_ZERO + v / 8'd10);
      run_chars.push_back(ppmat_pkg::CH_ZERO + v % 8'd10);
    end else begin
      run_chars.push_back(ppmat_pkg::CH_ZERO + v);
    end
  endfunction

  function automatic void render_byte(input logic [7:0] b);
    logic [DIM_BITS-1:0] v;
    text_char_t          t;
    run_chars = {};
    case (step)
      STEP_MAGIC0: step = STEP_MAGIC1;
      STEP_MAGIC1: step = STEP_MAGIC2;
      STEP_MAGIC2: step = STEP_WIDTH;
      STEP_PIXELS: begin
        case (comp)
          ppmat_pkg::KIND_C0: begin
            run_chars = {ppmat_pkg::CH_ESC, ppmat_pkg::CH_LBR, ppmat_pkg::CH_THREE,
                         ppmat_pkg::CH_EIGHT, ppmat_pkg::CH_SEMI, ppmat_pkg::CH_TWO,
                         ppmat_pkg::CH_SEMI};
            add_decimal(b);
            run_chars.push_back(ppmat_pkg::CH_SEMI);
            comp = ppmat_pkg::KIND_C1;
          end
          ppmat_pkg::KIND_C1: begin
            add_decimal(b);
            run_chars.push_back(ppmat_pkg::CH_SEMI);
            comp = ppmat_pkg::KIND_C2;
          end
          default: begin
            add_decimal(b);
            run_chars.push_back(ppmat_pkg::CH_M);
            run_chars.push_back(ppmat_pkg::BLK_B0);
            run_chars.push_back(ppmat_pkg::BLK_B1);
            run_chars.push_back(ppmat_pkg::BLK_B2);
            run_chars.push_back(ppmat_pkg::CH_ESC);
            run_chars.push_back(ppmat_pkg::CH_LBR);
            run_chars.push_back(ppmat_pkg::CH_ZERO);
            run_chars.push_back(ppmat_pkg::CH_M);
            comp = ppmat_pkg::KIND_C0;
            col = col + 1'b1;
            if (col == img_w) begin
              run_chars.push_back(ppmat_pkg::CH_NL);
              col = '0;
              row = row + 1'b1;
              if (row == img_h) begin
                row = '0;
                step = STEP_MAGIC0;
              end
            end
          end
        endcase
      end
      default: begin
        if (b == ppmat_pkg::CH_SPACE || b == ppmat_pkg::CH_NL) begin
          v = number_acc;
          number_acc = '0;
          case (step)
            STEP_WIDTH: begin
              img_w = v;
              step = STEP_HEIGHT;
            end
            STEP_HEIGHT: begin
              img_h = v;
              step = STEP_MAXVAL;
            end
            default: begin
              col = '0;
              row = '0;
              comp = ppmat_pkg::KIND_C0;
              step = (img_w == '0 || img_h == '0) ? STEP_MAGIC0 : STEP_PIXELS;
            end
          endcase
        end else begin
          number_acc = DIM_BITS'(number_acc * 10 + b - ppmat_pkg::CH_ZERO);
        end
      end
    endcase
    foreach (run_chars[i]) begin
      t.ch = run_chars[i];
      t.ends_run = (i == run_chars.size() - 1);
      text_expected.push_back(t);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      step = STEP_MAGIC0;
      number_acc = '0;
      img_w = '0;
      img_h = '0;
      col = '0;
      row = '0;
      comp = ppmat_pkg::KIND_C0;
      text_expected = {};
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        render_byte(in_ch.in_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (text_expected.size() == 0) begin
          $display("%0t: unexpected out_byte %02h (last_of_run %0b)", $time,
                   out_ch.out_byte, out_ch.last_of_run);
          fail_count++;
        end else begin
          want = text_expected.pop_front();
          if (out_ch.out_byte !== want.ch) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.ch,
                     out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.last_of_run !== want.ends_run) begin
            $display("%0t: last_of_run expected %0b, got %0b", $time, want.ends_run,
                     out_ch.last_of_run);
            fail_count++;
          end
        end
      end
    end
    pending = text_expected.size();
  end

endmodule

@@ tb/sv/ppm_to_ansi_truecolor_text_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppm_to_ansi_truecolor_text_tb
// Feeds the converter a short hand-written stream, then randomly shaped
// images with random idling on both channels, and reports the verdict from
// the failure count of the checker.
// ---------------------------------------------------------------------------
module ppm_to_ansi_truecolor_text_tb;

  localparam int unsigned DIM_BITS = 16;
  localparam int ITEM_TARGET = 280;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic out_fire = 1'b0;
  logic in_quiet = 1'b0;
  logic out_quiet = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   sent = 0;
  int   out_wait = 0;

  ppmat_in_if  in_ch ();
  ppmat_out_if out_ch ();

  ppm_to_ansi_truecolor_text #(
    .DIM_BITS(DIM_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  ppm_text_checker #(
    .DIM_BITS(DIM_BITS)
  ) text_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_fire <= rst_n && out_ch.valid && out_ch.ready;
  end

  always @(negedge clk) begin
    if (out_fire) begin
      out_wait = out_quiet ? 0 : $urandom_range(0, 15);
    end else if (out_wait != 0) begin
      out_wait = out_wait - 1;
    end
    out_ch.ready <= (out_wait == 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[ppm_to_ansi_truecolor_text] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_number(input int unsigned v);
    logic [7:0] digs[$];
    int         pad;
    do begin
      digs.push_front(ppmat_pkg::CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
    repeat (pad) digs.push_front(ppmat_pkg::CH_ZERO);
    foreach (digs[i]) send_byte(digs[i]);
    send_byte($urandom_range(0, 1) ? ppmat_pkg::CH_SPACE : ppmat_pkg::CH_NL);
  endtask

  // Any byte other than a terminator is folded into the number unchecked.
  task automatic send_junk_number();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      do b = 8'($urandom_range(0, 255));
      while (b == ppmat_pkg::CH_SPACE || b == ppmat_pkg::CH_NL);
      send_byte(b);
    end
    send_byte(ppmat_pkg::CH_SPACE);
  endtask

  task automatic send_image();
    int unsigned w;
    int unsigned h;
    int unsigned shape;
    logic [7:0]  corner[6];
    corner = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd255};
    shape = $urandom_range(0, 11);
    in_quiet = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 3);
    if (shape == 0) begin
      w = 0;
      h = $urandom_range(0, 5);
    end else if (shape == 1) begin
      h = 0;
    end
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    if (shape == 1 && $urandom_range(0, 1) == 1) begin
      send_junk_number();
    end else if (shape == 2) begin
      send_number(w + (32'd1 << DIM_BITS));
    end else begin
      send_number(w);
    end
    send_number(h);
    if (shape == 3) begin
      send_junk_number();
    end else begin
      send_number($urandom_range(0, 1) ? 255 : $urandom_range(0, 65535));
    end
    repeat (w * h * 3) begin
      send_byte(($urandom_range(0, 3) == 0) ? corner[$urandom_range(0, 5)]
                                           : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain_text();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0] opening[$];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A two-pixel image covering one, two and three digit components, then an
    // image of zero width that must produce no text at all.
    opening = {8'h50, 8'h36, ppmat_pkg::CH_NL, ppmat_pkg::CH_TWO, ppmat_pkg::CH_SPACE,
               8'h31, ppmat_pkg::CH_NL, 8'h39, ppmat_pkg::CH_SPACE,
               8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd255,
               8'h50, 8'h36, ppmat_pkg::CH_SPACE, ppmat_pkg::CH_ZERO, ppmat_pkg::CH_NL,
               8'h35, ppmat_pkg::CH_SPACE, 8'h31, ppmat_pkg::CH_NL};
    foreach (opening[i]) send_byte(opening[i]);
    drain_text();

    while (sent < ITEM_TARGET) begin
      send_image();
      if ($urandom_range(0, 7) == 0) begin
        drain_text();
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ppm_to_ansi_truecolor_text] OK");
    end else begin
      $display("[ppm_to_ansi_truecolor_text] ERROR");
    end
    $finish;
  end

endmodule

@@ ppm_to_ansi_truecolor_text.f @@
hw/rtl/ppmat_pkg.sv
hw/rtl/ppmat_if.sv
hw/rtl/ppmat_front.sv
hw/rtl/ppmat_queue.sv
hw/rtl/ppmat_back.sv
hw/rtl/ppm_to_ansi_truecolor_text.sv
hw/rtl/ppmat_checker.sv
tb/sv/ppm_text_checker.sv
tb/sv/ppm_to_ansi_truecolor_text_tb.sv
